// ===== sv/gbn_pkg.sv =====
// shared types and constants for the go-back-n sender
`timescale 1ns / 1ps
package gbn_pkg;
	localparam int SLOTS_DEF = 1024;
	localparam int WIN_MAX = 64;
	localparam logic [6:0] WIN_RST = 7'd8;
	localparam logic [15:0] TMO_RST = 16'd15;
	localparam int NWORDS = 5;
	localparam int SUM_W = 13;

	localparam logic [1:0] FN_MSG = 2'd0;
	localparam logic [1:0] FN_ACK = 2'd1;
	localparam logic [1:0] FN_TICK = 2'd2;

	localparam logic [2:0] ADDR_WIN = 3'd0;
	localparam logic [2:0] ADDR_TMO = 3'd4;

	typedef struct packed {
		logic signed [SUM_W-1:0] bsum;
		logic [32*NWORDS-1:0] words;
	} slot_t;
endpackage

// ===== sv/go_back_n_sender.sv =====
// go-back-n sender top level: config registers, sequencer, timer, output register
// steps: request taken in idle, payload words summed, a decision, then a check and a read
// per packet sent (0 to 64); new requests are taken only in idle, at a pace
// set by the byte summer (one payload word per cycle) and the single slot memory read port
// reset: base, send and free counters to 1, timer stopped, window 8, timeout 15;
// slot memory is not cleared
`timescale 1ns / 1ps
module go_back_n_sender #(
	parameter int SLOTS = gbn_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic signed [31:0] pkt_seq,
	input  logic signed [31:0] pkt_ack,
	input  logic signed [31:0] pkt_checksum,
	input  logic [63:0] payload_0,
	input  logic [63:0] payload_1,
	input  logic [31:0] payload_2,
	output logic out_valid,
	input  logic out_ready,
	output logic [31:0] seq_out,
	output logic signed [31:0] checksum_out,
	output logic [63:0] data_out_0,
	output logic [63:0] data_out_1,
	output logic [31:0] data_out_2,
	output logic last
);
	import gbn_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM = 3'd1;
	localparam logic [2:0] ST_DEC = 3'd2;
	localparam logic [2:0] ST_CHK = 3'd3;
	localparam logic [2:0] ST_RD = 3'd4;

	logic [2:0] state_q;
	logic [6:0] win_reg_q;
	logic [15:0] tmo_q;
	logic [1:0] func_q;
	logic [31:0] pseq_q, pack_q, pchk_q;
	logic [32*NWORDS-1:0] words_q;
	logic [2:0] wcnt_q;
	logic [31:0] base_q, next_send_q, next_free_q, cur_q;
	logic [IW-1:0] base_idx_q, send_idx_q, free_idx_q, cur_idx_q;
	logic timer_run_q;
	logic [15:0] timer_left_q;
	logic mode_new_q;
	logic out_valid_q, last_q;
	logic [31:0] seq_out_q, chk_out_q;
	logic [32*NWORDS-1:0] data_out_q;

	logic wr;
	logic in_acc;
	logic signed [SUM_W-1:0] bsum;
	logic [31:0] bsum_ext;
	logic [6:0] win;
	logic ack_ok;
	logic [31:0] new_base, adv;
	logic [IW:0] idx_sum;
	logic [IW-1:0] new_base_idx;
	logic cond_new, more;
	logic ram_we, ram_re;
	slot_t ram_wdata, ram_rdata;

	function automatic logic [IW-1:0] idx_inc(input logic [31:0] s, input logic [IW-1:0] i);
		logic [IW-1:0] r;
		if (s == 32'hFFFF_FFFF) begin
			r = '0;
		end else if (i == IW'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid & in_ready;

	always_comb begin
		case (paddr)
			ADDR_WIN: prdata = {25'd0, win_reg_q};
			ADDR_TMO: prdata = {16'd0, tmo_q};
			default:  prdata = '0;
		endcase
	end

	gbn_bsum u_bsum (
		.clk(clk),
		.arst_n(arst_n),
		.clr(in_acc),
		.en(state_q == ST_SUM),
		.word(words_q[wcnt_q*32 +: 32]),
		.sum(bsum)
	);

	assign bsum_ext = 32'(bsum);
	assign win = (win_reg_q > 7'(WIN_MAX)) ? 7'(WIN_MAX) : win_reg_q;
	assign ack_ok = ((pseq_q + pack_q + bsum_ext) == pchk_q)
		&& ((pack_q - base_q) < (next_send_q - base_q));
	assign new_base = pack_q + 32'd1;
	assign adv = new_base - base_q;
	assign idx_sum = {1'b0, base_idx_q} + adv[IW:0];

	always_comb begin
		if (new_base < base_q) begin
			new_base_idx = new_base[IW-1:0];
		end else if (idx_sum >= (IW+1)'(SLOTS)) begin
			new_base_idx = IW'(idx_sum - (IW+1)'(SLOTS));
		end else begin
			new_base_idx = idx_sum[IW-1:0];
		end
	end

	assign cond_new = (next_send_q != next_free_q) && ((next_send_q - base_q) < {25'd0, win});
	assign more = mode_new_q ? cond_new : ((cur_q + 32'd1) != next_send_q);

	assign ram_we = (state_q == ST_DEC) && (func_q == FN_MSG)
		&& ((next_free_q - base_q) < 32'(SLOTS));
	assign ram_wdata.bsum = bsum;
	assign ram_wdata.words = words_q;
	assign ram_re = (state_q == ST_CHK)
		&& (mode_new_q ? cond_new : (cur_q != next_send_q));

	gbn_slot_ram #(.DEPTH(SLOTS), .AW(IW)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(free_idx_q),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(cur_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_reg_q <= WIN_RST;
			tmo_q <= TMO_RST;
		end else if (wr) begin
			if (paddr[2]) begin
				tmo_q <= pwdata[15:0];
			end else begin
				win_reg_q <= pwdata[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			pseq_q <= pkt_seq;
			pack_q <= pkt_ack;
			pchk_q <= pkt_checksum;
			words_q <= {payload_2, payload_1, payload_0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wcnt_q <= '0;
			base_q <= 32'd1;
			next_send_q <= 32'd1;
			next_free_q <= 32'd1;
			cur_q <= 32'd1;
			base_idx_q <= IW'(1);
			send_idx_q <= IW'(1);
			free_idx_q <= IW'(1);
			cur_idx_q <= IW'(1);
			timer_run_q <= 1'b0;
			timer_left_q <= '0;
			mode_new_q <= 1'b0;
			out_valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_RD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wcnt_q <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					wcnt_q <= wcnt_q + 3'd1;
					if (wcnt_q == 3'(NWORDS - 1)) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					state_q <= ST_IDLE;
					case (func_q)
						FN_MSG: begin
							if (ram_we) begin
								next_free_q <= next_free_q + 32'd1;
								free_idx_q <= idx_inc(next_free_q, free_idx_q);
								mode_new_q <= 1'b1;
								cur_q <= next_send_q;
								cur_idx_q <= send_idx_q;
								state_q <= ST_CHK;
							end
						end
						FN_ACK: begin
							if (ack_ok) begin
								base_q <= new_base;
								base_idx_q <= new_base_idx;
								if (new_base == next_send_q) begin
									timer_run_q <= 1'b0;
									mode_new_q <= 1'b1;
									cur_q <= next_send_q;
									cur_idx_q <= send_idx_q;
									state_q <= ST_CHK;
								end else begin
									timer_run_q <= 1'b1;
									timer_left_q <= tmo_q;
								end
							end
						end
						FN_TICK: begin
							if (timer_run_q) begin
								if (timer_left_q <= 16'd1) begin
									timer_left_q <= tmo_q;
									mode_new_q <= 1'b0;
									cur_q <= base_q;
									cur_idx_q <= base_idx_q;
									state_q <= ST_CHK;
								end else begin
									timer_left_q <= timer_left_q - 16'd1;
								end
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_CHK: begin
					if (ram_re) begin
						if (mode_new_q) begin
							if (next_send_q == base_q) begin
								timer_run_q <= 1'b1;
								timer_left_q <= tmo_q;
							end
							next_send_q <= next_send_q + 32'd1;
							send_idx_q <= idx_inc(next_send_q, send_idx_q);
						end
						state_q <= ST_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						last_q <= !more;
						cur_q <= cur_q + 32'd1;
						cur_idx_q <= idx_inc(cur_q, cur_idx_q);
						state_q <= more ? ST_CHK : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RD) && (!out_valid_q || out_ready)) begin
			seq_out_q <= cur_q;
			chk_out_q <= cur_q + 32'(ram_rdata.bsum);
			data_out_q <= ram_rdata.words;
		end
	end

	assign out_valid = out_valid_q;
	assign seq_out = seq_out_q;
	assign checksum_out = chk_out_q;
	assign data_out_0 = data_out_q[63:0];
	assign data_out_1 = data_out_q[127:64];
	assign data_out_2 = data_out_q[159:128];
	assign last = last_q;

	a_outstanding_max: assert property (@(posedge clk) disable iff (!arst_n)
		(next_send_q - base_q) <= 32'(WIN_MAX))
		else $error("more packets outstanding than the largest window");
	a_buffered_max: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q - base_q) <= 32'(SLOTS))
		else $error("more packets buffered than slots");
	a_send_behind_free: assert property (@(posedge clk) disable iff (!arst_n)
		(next_send_q - base_q) <= (next_free_q - base_q))
		else $error("sent a packet that was never buffered");
	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!timer_run_q |-> (next_send_q == base_q))
		else $error("timer stopped with packets outstanding");
endmodule

// ===== sv/gbn_bsum.sv =====
// iterative signed byte summer, one 32-bit word per cycle while enabled
`timescale 1ns / 1ps
module gbn_bsum (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic en,
	input  logic [31:0] word,
	output logic signed [gbn_pkg::SUM_W-1:0] sum
);
	import gbn_pkg::*;

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] add;

	always_comb begin
		add = SUM_W'(signed'(word[7:0])) + SUM_W'(signed'(word[15:8]))
			+ SUM_W'(signed'(word[23:16])) + SUM_W'(signed'(word[31:24]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clr) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_q + add;
		end
	end

	assign sum = sum_q;
endmodule

// ===== sv/gbn_slot_ram.sv =====
// packet slot memory, one write and one registered read port
`timescale 1ns / 1ps
module gbn_slot_ram #(
	parameter int DEPTH = gbn_pkg::SLOTS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  gbn_pkg::slot_t wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output gbn_pkg::slot_t rdata
);
	import gbn_pkg::*;

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
